FILE: src/prqs_pkg.sv
// shared types and constants of the priority ready-queue scheduler
`timescale 1ns / 1ps

package prqs_pkg;

    localparam int FUNC_W = 2;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_MAKE_READY = 2'd0,
        FUNC_YIELD      = 2'd1,
        FUNC_BLOCK      = 2'd2,
        FUNC_SLICE      = 2'd3
    } func_t;

endpackage

FILE: src/priority_ready_queue_scheduler_core.sv
// Hardware thread scheduler with one FIFO ready queue per priority level and a
// nonempty-level mask. It takes one command per cycle while its result register
// is not held back by a low m_tready, and offers one result per command: a skid
// register holds the command and the whole queue update (priority encode, head
// pop, tail push and requeue of the old current thread) is done in one pass from
// that register into the result register, so the rate of one command per cycle
// is set by that single update of the small head, tail and link tables. The tables
// need no clearing after reset; the block accepts commands right out of reset.
`timescale 1ns / 1ps

module priority_ready_queue_scheduler_core
    import prqs_pkg::*;
#(
    parameter int NUM_PRIORITIES = 8,
    parameter int NUM_THREADS    = 16
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  logic                                       s_tvalid,
    output logic                                       s_tready,
    // func, thread_id, priority_req
    input  logic [((FUNC_W + $clog2(NUM_THREADS) + $clog2(NUM_PRIORITIES) + 7) / 8) * 8 - 1:0]
                                                       s_tdata,
    output logic                                       m_tvalid,
    input  logic                                       m_tready,
    // switched, prev_thread, next_thread, idle, force_resched, any_ready
    output logic [((2 * $clog2(NUM_THREADS) + 4 + 7) / 8) * 8 - 1:0]
                                                       m_tdata
);

    localparam int TW      = $clog2(NUM_THREADS);
    localparam int PW      = $clog2(NUM_PRIORITIES);
    localparam int IN_W    = ((FUNC_W + TW + PW + 7) / 8) * 8;
    localparam int OUT_BITS = 2 * TW + 4;
    localparam int OUT_W   = ((OUT_BITS + 7) / 8) * 8;
    localparam logic [PW-1:0] PRIO_MAX = PW'(NUM_PRIORITIES - 1);

    // skid register
    logic              in_valid_reg;
    func_t             in_func_reg;
    logic [TW-1:0]     in_tid_reg;
    logic [PW-1:0]     in_prio_reg;

    // result register
    logic              m_tvalid_reg;
    logic [OUT_W-1:0]  m_tdata_reg, m_tdata_next;

    // scheduler state
    logic [NUM_PRIORITIES-1:0] mask_reg, mask_next;
    logic [NUM_THREADS-1:0]    ready_reg, ready_next;
    logic [TW-1:0]             cur_reg, cur_next;
    logic [PW-1:0]             cur_prio_reg, cur_prio_next;
    logic                      running_reg, running_next;

    logic [TW-1:0] head_mem [NUM_PRIORITIES];
    logic [TW-1:0] tail_mem [NUM_PRIORITIES];
    logic [TW-1:0] link_mem [NUM_THREADS];
    logic [PW-1:0] prio_mem [NUM_THREADS];

    logic          advance;

    // update controls
    logic [PW-1:0] top_p;
    logic          any_ready;
    logic          force_bit;
    logic          pop_we;
    logic [TW-1:0] pop_t;
    logic          pop_last;
    logic          push_en;
    logic [TW-1:0] push_t;
    logic [PW-1:0] push_p;
    logic          push_to_empty;
    logic          prio_we;
    logic [PW-1:0] prio_sat;

    assign advance  = in_valid_reg && (!m_tvalid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // highest nonempty level
    always_comb begin
        top_p = '0;
        for (int p = 0; p < NUM_PRIORITIES; p++) begin
            if (mask_reg[p]) begin
                top_p = PW'(p);
            end
        end
    end

    assign any_ready = |mask_reg;
    assign prio_sat  = (in_prio_reg > PRIO_MAX) ? PRIO_MAX : in_prio_reg;
    assign pop_t     = head_mem[top_p];
    assign pop_last  = (pop_t == tail_mem[top_p]);

    always_comb begin
        logic [NUM_PRIORITIES-1:0] mask_base;
        logic                      do_block;
        logic                      tid_ok;

        mask_next     = mask_reg;
        ready_next    = ready_reg;
        cur_next      = cur_reg;
        cur_prio_next = cur_prio_reg;
        running_next  = running_reg;
        force_bit     = 1'b0;
        pop_we        = 1'b0;
        push_en       = 1'b0;
        push_t        = in_tid_reg;
        push_p        = prio_sat;
        prio_we       = 1'b0;
        mask_base     = mask_reg;
        do_block      = 1'b0;
        tid_ok        = ({1'b0, in_tid_reg} < (TW + 1)'(NUM_THREADS));

        unique case (in_func_reg)
            FUNC_MAKE_READY: begin
                if (tid_ok && !ready_reg[in_tid_reg]) begin
                    prio_we = 1'b1;
                    push_en = 1'b1;
                    if (in_tid_reg == cur_reg) begin
                        cur_prio_next = prio_sat;
                    end
                end
            end
            FUNC_YIELD, FUNC_BLOCK: begin
                do_block = (in_func_reg == FUNC_BLOCK) || !running_reg;
                if (do_block) begin
                    ready_next[cur_reg] = 1'b0;
                    if (!any_ready) begin
                        running_next = 1'b0;
                    end
                end
                if (any_ready) begin
                    pop_we = !pop_last;
                    if (pop_last) begin
                        mask_base[top_p] = 1'b0;
                    end
                    if (pop_t != cur_reg) begin
                        // old current goes back to its queue only if still running
                        if (!do_block && running_reg && ready_reg[cur_reg]) begin
                            push_en = 1'b1;
                            push_t  = cur_reg;
                            push_p  = cur_prio_reg;
                        end
                        cur_next      = pop_t;
                        cur_prio_next = prio_mem[pop_t];
                    end
                    running_next = 1'b1;
                end
            end
            FUNC_SLICE: begin
                force_bit = any_ready && (cur_prio_reg <= top_p);
            end
            default: begin
            end
        endcase

        push_to_empty = !mask_base[push_p];
        mask_next     = mask_base;
        if (push_en) begin
            ready_next[push_t] = 1'b1;
            mask_next[push_p]  = 1'b1;
        end
    end

    // result item
    always_comb begin
        m_tdata_next                = '0;
        m_tdata_next[0]             = (cur_next != cur_reg);
        m_tdata_next[1 +: TW]       = cur_reg;
        m_tdata_next[TW + 1 +: TW]  = cur_next;
        m_tdata_next[2 * TW + 1]    = !running_next;
        m_tdata_next[2 * TW + 2]    = force_bit;
        m_tdata_next[2 * TW + 3]    = |mask_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
            mask_reg     <= '0;
            ready_reg    <= NUM_THREADS'(1);
            cur_reg      <= '0;
            cur_prio_reg <= '0;
            running_reg  <= 1'b1;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                m_tvalid_reg <= 1'b1;
                mask_reg     <= mask_next;
                ready_reg    <= ready_next;
                cur_reg      <= cur_next;
                cur_prio_reg <= cur_prio_next;
                running_reg  <= running_next;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_func_reg <= func_t'(s_tdata[FUNC_W-1:0]);
            in_tid_reg  <= s_tdata[FUNC_W +: TW];
            in_prio_reg <= s_tdata[FUNC_W + TW +: PW];
        end
        if (advance) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    // queue tables
    always_ff @(posedge aclk) begin
        if (advance) begin
            if (pop_we) begin
                head_mem[top_p] <= link_mem[pop_t];
            end
            if (push_en) begin
                if (push_to_empty) begin
                    head_mem[push_p] <= push_t;
                end else begin
                    link_mem[tail_mem[push_p]] <= push_t;
                end
                tail_mem[push_p] <= push_t;
            end
        end
    end

    // thread priorities, the main thread starts at the lowest level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prio_mem[0] <= '0;
        end else if (advance && prio_we) begin
            prio_mem[in_tid_reg] <= prio_sat;
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tready) |=> (m_tvalid_reg && $stable(m_tdata_reg)))
        else $error("waiting result item changed or dropped");

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("held input item dropped");

    a_switch_runs: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_tdata_reg[0]) |-> !m_tdata_reg[2 * TW + 1])
        else $error("switch reported while going idle");

    a_pop_needs_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && pop_we) |-> any_ready)
        else $error("queue pop with no ready level");

    // unused top input bits only pad the item
    logic unused_pad;
    assign unused_pad = ^{s_tdata[IN_W-1:FUNC_W + TW + PW], 1'b0};

endmodule
